// ===== rtl/xsrd_pkg.sv =====
// Package for the XOR sprite row draw block: screen geometry, derived widths
// and the sequencer state type. No dependencies.
package xsrd_pkg;

   localparam int SCREEN_WIDTH  = 64;   // 16 .. 128
   localparam int SCREEN_HEIGHT = 32;   // 16 .. 64

   localparam int COL_AW = $clog2(SCREEN_WIDTH);
   localparam int ROW_AW = $clog2(SCREEN_HEIGHT);

   // working value: holds an 8-bit origin and a column of up to width + 14
   localparam int ACC_W = 9;

   localparam int HALF_OFFSET = 8;   // right half of a 16-wide sprite
   localparam int ROW_PIXELS  = 8;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_X,
      ST_RED_Y,
      ST_ROW_FIT,
      ST_READ,
      ST_PIXEL,
      ST_WRITE,
      ST_FINISH
   } xsrd_state_type;

endpackage

// ===== rtl/xor_sprite_row_draw_top.sv =====
// XOR sprite row draw block: frame store, sequencer and shared compare/subtract unit.
// Depends on xsrd_pkg.

// One-bit frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels that XORs one eight-pixel
// sprite row per draw beat and answers each beat with the collision flag and a
// row-clipped bit. One item is worked on at a time; req_ready is high only while the
// sequencer is idle, and a waiting response does not block the next request. A clear
// beat wipes the store at once through per-row valid bits. A draw beat reduces both
// origins by repeated subtraction in the single compare/subtract unit; unless the row
// is clipped, it then reads the frame row, places the eight pixels one per cycle
// through the same unit and writes the row back. A csr write takes effect at once, so
// write it only while the block is idle with no response waiting.
module xor_sprite_row_draw_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_x_origin,
   input  logic [7:0] req_y_origin,
   input  logic [3:0] req_row_index,
   input  logic       req_right_half,
   input  logic [7:0] req_row_data,
   input  logic       req_first_row,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_collision,
   output logic       rsp_row_clipped
);
   import xsrd_pkg::*;

   xsrd_state_type state_ff, state_in;

   logic                    wrap_ff;
   logic                    coll_ff;
   logic                    clip_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_coll_ff;
   logic                    rsp_clip_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [ACC_W-1:0]        col_ff;
   logic [3:0]              ri_ff;
   logic                    rh_ff;
   logic [7:0]              data_ff;
   logic [2:0]              bit_ff;
   logic [ROW_AW-1:0]       row_addr_ff;
   logic [SCREEN_WIDTH-1:0] row_ff;
   logic [SCREEN_HEIGHT-1:0] row_valid_ff;
   logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];

   // y origin held from the request beat until the x reduction is done
   logic [7:0]              req_y_origin_hold;
   logic [7:0]              y_hold_ff;

   // shared compare/subtract unit
   logic [ACC_W-1:0] unit_sub;
   logic [ACC_W-1:0] unit_diff;
   logic             unit_ge;

   logic             req_fire;
   logic             finish_go;
   logic             pix_lit;
   logic             pix_hit;
   logic [COL_AW-1:0] pix_idx;

   assign unit_diff = acc_ff - unit_sub;
   assign unit_ge   = (acc_ff >= unit_sub);
   assign req_fire  = req_valid && req_ready;
   assign pix_lit   = data_ff[~bit_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_operation == OP_CLEAR) ? ST_FINISH : ST_RED_X;
            end
         end
         ST_RED_X: begin
            if (!unit_ge) state_in = ST_RED_Y;
         end
         ST_RED_Y: begin
            if (!unit_ge) state_in = ST_ROW_FIT;
         end
         ST_ROW_FIT: begin
            state_in = (unit_ge && !wrap_ff) ? ST_FINISH : ST_READ;
         end
         ST_READ:  state_in = ST_PIXEL;
         ST_PIXEL: begin
            if (bit_ff == 3'(ROW_PIXELS - 1)) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (finish_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      finish_go = 1'b0;
      unit_sub  = ACC_W'(SCREEN_WIDTH);
      pix_hit   = 1'b0;
      pix_idx   = acc_ff[COL_AW-1:0];
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RED_Y, ST_ROW_FIT: unit_sub = ACC_W'(SCREEN_HEIGHT);
         ST_PIXEL: begin
            // column past the right edge either wraps once or is dropped
            if (unit_ge) begin
               pix_hit = pix_lit && wrap_ff;
               pix_idx = unit_diff[COL_AW-1:0];
            end else begin
               pix_hit = pix_lit;
            end
         end
         ST_FINISH: finish_go = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wrap_ff      <= 1'b0;
         coll_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) wrap_ff <= csr_wr_data;
         if (req_fire) begin
            if (req_operation == OP_CLEAR) begin
               row_valid_ff <= '0;
            end else if (req_first_row) begin
               coll_ff <= 1'b0;
            end
         end
         if (state_ff == ST_PIXEL && pix_hit && row_ff[pix_idx]) coll_ff <= 1'b1;
         if (state_ff == ST_WRITE) row_valid_ff[row_addr_ff] <= 1'b1;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_coll_ff <= coll_ff;
         rsp_clip_ff <= clip_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            acc_ff  <= ACC_W'(req_x_origin);
            ri_ff   <= req_row_index;
            rh_ff   <= req_right_half;
            data_ff <= req_row_data;
            clip_ff <= 1'b0;
         end
         ST_RED_X: begin
            if (unit_ge) begin
               acc_ff <= unit_diff;
            end else begin
               col_ff <= acc_ff + (rh_ff ? ACC_W'(HALF_OFFSET) : '0);
               acc_ff <= ACC_W'(req_y_origin_hold);
            end
         end
         ST_RED_Y: begin
            acc_ff <= unit_ge ? unit_diff : acc_ff + ACC_W'(ri_ff);
         end
         ST_ROW_FIT: begin
            if (unit_ge) begin
               if (wrap_ff) begin
                  acc_ff <= unit_diff;
               end else begin
                  clip_ff <= 1'b1;
               end
            end
         end
         ST_READ: begin
            row_addr_ff <= acc_ff[ROW_AW-1:0];
            row_ff      <= row_valid_ff[acc_ff[ROW_AW-1:0]] ?
                           frame_mem[acc_ff[ROW_AW-1:0]] : '0;
            acc_ff      <= col_ff;
            bit_ff      <= '0;
         end
         ST_PIXEL: begin
            if (pix_hit) row_ff[pix_idx] <= ~row_ff[pix_idx];
            acc_ff <= acc_ff + ACC_W'(1);
            bit_ff <= bit_ff + 3'd1;
         end
         ST_WRITE: frame_mem[row_addr_ff] <= row_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) y_hold_ff <= req_y_origin;
   end
   assign req_y_origin_hold = y_hold_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_collision   = rsp_coll_ff;
   assign rsp_row_clipped = rsp_clip_ff;

endmodule

// ===== rtl/xsrd_checker.sv =====
// Port-level checker for xor_sprite_row_draw_top, attached by bind.
// Depends on the top level's ports only.
module xsrd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_collision,
   input logic rsp_row_clipped
);
   logic [1:0] pending_ff;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_beat) - 2'(rsp_beat);
      end
   end

   // a response beat is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_collision)
                                  && $stable(rsp_row_clipped))
      else $error("response changed while stalled");

   // one item in work at a time: busy right after a request beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken while busy");

   // no response without an item behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without request");

   // at most one in work plus one waiting
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many items outstanding");

endmodule

bind xor_sprite_row_draw_top xsrd_checker u_xsrd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_collision   (rsp_collision),
   .rsp_row_clipped (rsp_row_clipped)
);

// ===== tb/tb_xor_sprite_row_draw_top.sv =====
// Self-checking testbench for xor_sprite_row_draw_top: XOR row drawing into the
// frame store, clipping and wrapping at the edges, clears and the collision flag.
// Depends on xsrd_pkg and the RTL of xor_sprite_row_draw_top.
module tb_xor_sprite_row_draw_top;
   timeunit 1ns;
   timeprecision 1ps;

   import xsrd_pkg::*;

   localparam int ITEM_TARGET   = 1100;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int WDOG_LIMIT    = 4000;

   typedef struct packed {
      logic       operation;
      logic [7:0] x_origin;
      logic [7:0] y_origin;
      logic [3:0] row_index;
      logic       right_half;
      logic [7:0] row_data;
      logic       first_row;
   } draw_beat_type;

   typedef struct packed {
      logic collision;
      logic row_clipped;
   } draw_flags_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   logic       req_operation;
   logic [7:0] req_x_origin;
   logic [7:0] req_y_origin;
   logic [3:0] req_row_index;
   logic       req_right_half;
   logic [7:0] req_row_data;
   logic       req_first_row;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_collision;
   logic       rsp_row_clipped;

   // predicted frame store and flags
   logic [SCREEN_WIDTH-1:0] screen_px [SCREEN_HEIGHT];
   logic                    sticky_hit;
   logic                    wrap_on;

   draw_flags_type pending_flags [$];

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   bit hold_req       = 1'b0;
   int beats_sent     = 0;
   int clears_sent    = 0;
   int rsp_seen       = 0;
   int hits_seen      = 0;
   int clips_seen     = 0;
   int err_cnt        = 0;
   int quiet_cycles   = 0;

   xor_sprite_row_draw_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_x_origin    (req_x_origin),
      .req_y_origin    (req_y_origin),
      .req_row_index   (req_row_index),
      .req_right_half  (req_right_half),
      .req_row_data    (req_row_data),
      .req_first_row   (req_first_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_collision   (rsp_collision),
      .rsp_row_clipped (rsp_row_clipped)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // XOR one row byte into the predicted store, return the flags for this beat
   function automatic draw_flags_type xor_row_into_screen(draw_beat_type b);
      int unsigned row;
      int unsigned col;
      int unsigned c;
      draw_flags_type f;
      f.row_clipped = 1'b0;
      if (b.operation == OP_CLEAR) begin
         foreach (screen_px[i]) screen_px[i] = '0;
      end else begin
         row = b.y_origin % SCREEN_HEIGHT + b.row_index;
         col = b.x_origin % SCREEN_WIDTH + (b.right_half ? HALF_OFFSET : 0);
         if (b.first_row) sticky_hit = 1'b0;
         if (wrap_on) row = row % SCREEN_HEIGHT;
         else if (row >= SCREEN_HEIGHT) f.row_clipped = 1'b1;
         if (!f.row_clipped) begin
            for (int p = 0; p < ROW_PIXELS; p++) begin
               if (b.row_data[ROW_PIXELS-1-p]) begin
                  c = col + p;
                  if (wrap_on) c = c % SCREEN_WIDTH;
                  // without wrap, columns past the right edge are dropped
                  if (c < SCREEN_WIDTH) begin
                     if (screen_px[row][c]) sticky_hit = 1'b1;
                     screen_px[row][c] = ~screen_px[row][c];
                  end
               end
            end
         end
      end
      f.collision = sticky_hit;
      return f;
   endfunction

   function automatic draw_beat_type mk_beat(logic op, logic [7:0] x, logic [7:0] y,
                                             logic [3:0] ri, logic rh, logic [7:0] data,
                                             logic first);
      draw_beat_type b;
      b.operation  = op;
      b.x_origin   = x;
      b.y_origin   = y;
      b.row_index  = ri;
      b.right_half = rh;
      b.row_data   = data;
      b.first_row  = first;
      return b;
   endfunction

   function automatic draw_beat_type rand_beat(logic op);
      return mk_beat(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     4'($urandom_range(15)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
   endfunction

   // called right after a rising edge; returns at the edge the beat is accepted
   // with req_valid still high
   task automatic send_beat(input draw_beat_type b);
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_valid      <= 1'b1;
      req_operation  <= b.operation;
      req_x_origin   <= b.x_origin;
      req_y_origin   <= b.y_origin;
      req_row_index  <= b.row_index;
      req_right_half <= b.right_half;
      req_row_data   <= b.row_data;
      req_first_row  <= b.first_row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_flags.push_back(xor_row_into_screen(b));
      beats_sent++;
      if (b.operation == OP_CLEAR) clears_sent++;
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_wrap(input logic v);
      settle_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      wrap_on = v;
   endtask

   task automatic send_sprite(input logic [7:0] x, input logic [7:0] y, input int rows_n,
                              input bit wide, input logic [7:0] glyph [16][2]);
      for (int r = 0; r < rows_n; r++) begin
         send_beat(mk_beat(OP_DRAW, x, y, 4'(r), 1'b0, glyph[r][0], r == 0));
         if (wide) send_beat(mk_beat(OP_DRAW, x, y, 4'(r), 1'b1, glyph[r][1], 1'b0));
      end
   endtask

   // draw, erase on redraw, clear keeps the flag, empty byte
   task automatic test_erase_and_clear();
      send_beat(mk_beat(OP_DRAW, 8'h00, 8'h00, 4'h0, 1'b0, 8'hFF, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'h00, 8'h00, 4'h0, 1'b0, 8'hFF, 1'b0));
      send_beat(rand_beat(OP_CLEAR));
      send_beat(mk_beat(OP_DRAW, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'h00, 8'h00, 4'h0, 1'b0, 8'hFF, 1'b0));
   endtask

   task automatic test_clipping();
      send_beat(mk_beat(OP_DRAW, 8'hFF, 8'hFF, 4'hF, 1'b1, 8'hFF, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1), 4'h0, 1'b0,
                        8'hFF, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'(SCREEN_WIDTH - 4), 8'(SCREEN_HEIGHT - 1), 4'h0, 1'b1,
                        8'hFF, 1'b0));
      send_beat(mk_beat(OP_DRAW, 8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1), 4'h0, 1'b0,
                        8'hFF, 1'b0));
      // row just past the bottom; first_row still drops the flag
      send_beat(mk_beat(OP_DRAW, 8'h10, 8'(SCREEN_HEIGHT - 1), 4'h1, 1'b0, 8'hFF, 1'b1));
   endtask

   task automatic test_wrapping();
      send_beat(mk_beat(OP_DRAW, 8'hFF, 8'hFF, 4'hF, 1'b1, 8'hA5, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'hFF, 8'hFF, 4'hF, 1'b1, 8'hA5, 1'b0));
      send_beat(mk_beat(OP_DRAW, 8'(SCREEN_WIDTH - 2), 8'(SCREEN_HEIGHT - 1), 4'h1, 1'b0,
                        8'hFF, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'h00, 8'h00, 4'h0, 1'b0, 8'hFF, 1'b0));
      send_beat(rand_beat(OP_CLEAR));
      send_beat(mk_beat(OP_DRAW, 8'h80, 8'h40, 4'hF, 1'b0, 8'h01, 1'b1));
      send_beat(mk_beat(OP_DRAW, 8'h7F, 8'h3F, 4'h8, 1'b1, 8'h5A, 1'b0));
   endtask

   // receiver stops for a long stretch while beats keep coming
   task automatic test_output_hold_off();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_req = 1'b1;
      for (int i = 0; i < 8; i++) send_beat(rand_beat(OP_DRAW));
      settle_idle();
   endtask

   task automatic test_random_sprites();
      logic [7:0] glyph [16][2];
      logic [7:0] sx;
      logic [7:0] sy;
      int         rows_n;
      bit         wide;
      bit         have_glyph;
      int         pick;
      have_glyph = 1'b0;
      for (int k = 0; k < 4; k++) begin
         write_wrap(k[0]);
         case (k)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
            default: begin src_idle_pct = 10; sink_stall_pct = 10; end
         endcase
         while (beats_sent < ITEM_TARGET * (k + 1) / 4) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               send_beat(rand_beat(OP_CLEAR));
            end else if (pick < 12) begin
               send_beat(rand_beat(OP_DRAW));
            end else if (pick >= 70 && have_glyph) begin
               // same sprite again erases itself, like a game moving an object
               send_sprite(sx, sy, rows_n, wide, glyph);
            end else begin
               if ($urandom_range(2) == 0)
                  sx = 8'($urandom_range(SCREEN_WIDTH - 8, SCREEN_WIDTH - 1)
                          + SCREEN_WIDTH * $urandom_range(255 / SCREEN_WIDTH));
               else
                  sx = 8'($urandom_range(255));
               if ($urandom_range(2) == 0)
                  sy = 8'($urandom_range(SCREEN_HEIGHT - 8, SCREEN_HEIGHT - 1)
                          + SCREEN_HEIGHT * $urandom_range(255 / SCREEN_HEIGHT));
               else
                  sy = 8'($urandom_range(255));
               rows_n = ($urandom_range(4) == 0) ? 16 : $urandom_range(1, 15);
               wide   = ($urandom_range(2) == 0);
               foreach (glyph[r, h])
                  glyph[r][h] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
               have_glyph = 1'b1;
               send_sprite(sx, sy, rows_n, wide, glyph);
            end
         end
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin : sink
      int n;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            for (n = 1; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      draw_flags_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (rsp_collision === 1'b1) hits_seen++;
         if (rsp_row_clipped === 1'b1) clips_seen++;
         if (pending_flags.size() == 0) begin
            $error("response beat with no draw or clear pending");
            err_cnt++;
         end else begin
            want = pending_flags.pop_front();
            if (rsp_collision !== want.collision) begin
               $error("collision: expected %0b, got %0b", want.collision, rsp_collision);
               err_cnt++;
            end
            if (rsp_row_clipped !== want.row_clipped) begin
               $error("row_clipped: expected %0b, got %0b", want.row_clipped,
                      rsp_row_clipped);
               err_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      foreach (screen_px[i]) screen_px[i] = '0;
      sticky_hit = 1'b0;
      wrap_on    = 1'b0;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= 1'b0;
      req_valid      <= 1'b0;
      req_operation  <= OP_CLEAR;
      req_x_origin   <= '0;
      req_y_origin   <= '0;
      req_row_index  <= '0;
      req_right_half <= 1'b0;
      req_row_data   <= '0;
      req_first_row  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_wrap(1'b0);
      test_erase_and_clear();
      test_clipping();
      write_wrap(1'b1);
      test_wrapping();
      test_output_hold_off();
      test_random_sprites();
      settle_idle();

      $display("%0d beats sent (%0d clears) in clip and wrap modes, %0d responses checked",
               beats_sent, clears_sent, rsp_seen);
      $display("%0d responses with collision set, %0d rows dropped at the bottom",
               hits_seen, clips_seen);
      if (err_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/xsrd_pkg.sv
rtl/xor_sprite_row_draw_top.sv
rtl/xsrd_checker.sv
tb/tb_xor_sprite_row_draw_top.sv
